/* rtl/slcm_pkg.sv */
`timescale 1ns / 1ps
package slcm_pkg;
    localparam int NUMBER_WIDTH = 32;
    localparam int COUNT_WIDTH  = 32;
    localparam int ORDER_WIDTH  = $clog2(NUMBER_WIDTH + 1);
    localparam int STEP_WIDTH   = $clog2(NUMBER_WIDTH + 1);
    localparam int NUM_BYTES    = (NUMBER_WIDTH + 7) / 8;
    localparam int TDATA_IN_W   = NUM_BYTES * 8;

    typedef logic [NUMBER_WIDTH-1:0] num_t;

    // request to the shared restoring divider
    typedef struct packed {
        logic start;
        num_t dividend;
        num_t divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        num_t quotient;
        num_t remainder;
    } div_rsp_t;
endpackage

/* rtl/strong_liar_count_monier.sv */
`timescale 1ns / 1ps
// strong liar counter (monier's formula)
// s_axis: one 32-bit odd number per word on s_tdata
// m_axis: one result word per input, tdata = liar_count, tuser = bad_input
// even numbers or numbers below 3 give bad_input high and a count of 0,
// with m_tvalid raised from the S_DONE state through the output register
// the number is factored by trial division with odd divisors; each trial
// divisor and each gcd step goes through one shared restoring divider,
// by way of the request and response registers; a 32-bit prime takes
// some 32768 trial divisors
// one word is worked on at a time; s_tready is high only while idle
// the result sits in an output register until taken; if the receiver
// stalls the block holds it and keeps s_tready low
// reset (aresetn low, synchronous) returns to idle and drops m_tvalid
module strong_liar_count_monier (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [slcm_pkg::TDATA_IN_W-1:0] s_tdata,  // number
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [slcm_pkg::COUNT_WIDTH-1:0] m_tdata, // liar_count
    output logic        m_tuser                       // bad_input
);
    import slcm_pkg::*;

    div_req_t               req;
    div_rsp_t               rsp;
    logic                   idle, done, bad;
    logic [COUNT_WIDTH-1:0] cnt;
    logic                   out_valid_reg, out_valid_next;
    logic [COUNT_WIDTH-1:0] out_data_reg, out_data_next;
    logic                   out_user_reg, out_user_next;
    logic                   accept;

    // take a new word only when idle and the output slot is free
    assign s_tready = idle && !out_valid_reg;
    assign accept   = s_tvalid && s_tready;

    slcm_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .req(req), .rsp(rsp)
    );

    slcm_sequencer u_seq (
        .aclk(aclk), .aresetn(aresetn), .start(accept),
        .number(s_tdata[NUMBER_WIDTH-1:0]), .req(req), .rsp(rsp),
        .idle(idle), .done(done), .liar_count(cnt), .bad_input(bad)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (out_valid_reg && m_tready) out_valid_next = 1'b0;
        if (done) begin
            out_valid_next = 1'b1;
            out_data_next  = cnt;
            out_user_next  = bad;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`ifndef SYNTHESIS
    // a bad input always reports a zero count
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("bad input with nonzero count");
    // no new word while a result waits
    a_no_accept_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("accept while result pending");
    // a finished result never lands on an untaken one
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> !out_valid_reg)
        else $error("result overwritten");
`endif
endmodule

/* rtl/slcm_divider.sv */
`timescale 1ns / 1ps
module slcm_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  slcm_pkg::div_req_t req,
    output slcm_pkg::div_rsp_t rsp
);
    import slcm_pkg::*;

    // one quotient bit per cycle, restoring
    logic                  busy_reg, busy_next;
    logic [STEP_WIDTH-1:0] cnt_reg, cnt_next;
    num_t                  quo_reg, quo_next;
    num_t                  rem_reg, rem_next;
    num_t                  dsr_reg, dsr_next;
    logic                  done_reg, done_next;
    logic [NUMBER_WIDTH:0] trial;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[NUMBER_WIDTH-1]} - {1'b0, dsr_reg};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = STEP_WIDTH'(NUMBER_WIDTH);
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end else if (busy_reg) begin
            if (!trial[NUMBER_WIDTH]) begin
                rem_next = trial[NUMBER_WIDTH-1:0];
                quo_next = {quo_reg[NUMBER_WIDTH-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[NUMBER_WIDTH-2:0], quo_reg[NUMBER_WIDTH-1]};
                quo_next = {quo_reg[NUMBER_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_WIDTH'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;
endmodule

/* rtl/slcm_sequencer.sv */
`timescale 1ns / 1ps
module slcm_sequencer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  slcm_pkg::num_t      number,
    output slcm_pkg::div_req_t  req,
    input  slcm_pkg::div_rsp_t  rsp,
    output logic                idle,
    output logic                done,
    output logic [slcm_pkg::COUNT_WIDTH-1:0] liar_count,
    output logic                bad_input
);
    import slcm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_NODD, S_TRY, S_TRYW, S_STRIP, S_STRIPW, S_PRIME,
        S_POD, S_GCD, S_GCDW, S_MUL, S_SUM, S_FIN, S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    num_t                   nodd_reg, nodd_next;
    num_t                   rest_reg, rest_next;
    num_t                   d_reg, d_next;
    num_t                   p_reg, p_next;
    num_t                   ga_reg, ga_next;
    num_t                   gb_reg, gb_next;
    logic [COUNT_WIDTH-1:0] prod_reg, prod_next;
    logic [COUNT_WIDTH-1:0] sum_reg, sum_next;
    logic [COUNT_WIDTH-1:0] term_reg, term_next;
    logic [ORDER_WIDTH-1:0] r_reg, r_next;
    logic [ORDER_WIDTH-1:0] rmin_reg, rmin_next;
    logic [ORDER_WIDTH-1:0] v_reg, v_next;
    logic [ORDER_WIDTH-1:0] k_reg, k_next;
    logic                   bad_reg, bad_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    div_req_t               req_next;
    num_t                   pm1;

    always_comb begin
        state_next = state_reg;
        nodd_next = nodd_reg; rest_next = rest_reg; d_next = d_reg;
        p_next = p_reg; ga_next = ga_reg; gb_next = gb_reg;
        prod_next = prod_reg; sum_next = sum_reg; term_next = term_reg;
        r_next = r_reg; rmin_next = rmin_reg; v_next = v_reg; k_next = k_reg;
        bad_next = bad_reg; cnt_next = cnt_reg;
        req_next = '{start: 1'b0, dividend: rest_reg, divisor: d_reg};
        pm1 = p_reg - 1'b1;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    if (number < num_t'(3) || !number[0]) begin
                        bad_next = 1'b1;
                        cnt_next = '0;
                        state_next = S_DONE;
                    end else begin
                        bad_next = 1'b0;
                        nodd_next = number - 1'b1;
                        rest_next = number;
                        d_next = num_t'(3);
                        prod_next = COUNT_WIDTH'(1);
                        v_next = '0; rmin_next = '0;
                        state_next = S_NODD;
                    end
                end
            end
            S_NODD: begin
                // number-1 is nonzero and even here, one shift a cycle
                if (nodd_reg[0]) state_next = S_TRY;
                else nodd_next = nodd_reg >> 1;
            end
            S_TRY: begin
                if (rest_reg <= num_t'(1)) begin
                    sum_next = '0; term_next = COUNT_WIDTH'(1); k_next = '0;
                    state_next = S_SUM;
                end else begin
                    req_next = '{start: 1'b1, dividend: rest_reg, divisor: d_reg};
                    state_next = S_TRYW;
                end
            end
            S_TRYW: begin
                if (rsp.done) begin
                    if (d_reg > rsp.quotient) begin
                        p_next = rest_reg;
                        rest_next = num_t'(1);
                        state_next = S_PRIME;
                    end else if (rsp.remainder != '0) begin
                        d_next = d_reg + num_t'(2);
                        state_next = S_TRY;
                    end else begin
                        p_next = d_reg;
                        rest_next = rsp.quotient;
                        state_next = S_STRIP;
                    end
                end
            end
            S_STRIP: begin
                req_next = '{start: 1'b1, dividend: rest_reg, divisor: p_reg};
                state_next = S_STRIPW;
            end
            S_STRIPW: begin
                if (rsp.done) begin
                    if (rsp.remainder == '0) begin
                        rest_next = rsp.quotient;
                        state_next = S_STRIP;
                    end else begin
                        state_next = S_PRIME;
                    end
                end
            end
            S_PRIME: begin
                ga_next = nodd_reg;
                gb_next = pm1;
                r_next = '0;
                state_next = S_POD;
            end
            S_POD: begin
                // p-1 even and nonzero
                if (gb_reg[0]) state_next = S_GCD;
                else begin
                    gb_next = gb_reg >> 1;
                    r_next = r_reg + 1'b1;
                end
            end
            S_GCD: begin
                if (gb_reg == '0) state_next = S_MUL;
                else begin
                    req_next = '{start: 1'b1, dividend: ga_reg, divisor: gb_reg};
                    state_next = S_GCDW;
                end
            end
            S_GCDW: begin
                if (rsp.done) begin
                    ga_next = gb_reg;
                    gb_next = rsp.remainder;
                    state_next = S_GCD;
                end
            end
            S_MUL: begin
                prod_next = COUNT_WIDTH'(prod_reg * COUNT_WIDTH'(ga_reg));
                if (v_reg == '0 || r_reg < rmin_reg) rmin_next = r_reg;
                v_next = v_reg + 1'b1;
                state_next = S_TRY;
            end
            S_SUM: begin
                if (k_reg >= rmin_reg) state_next = S_FIN;
                else begin
                    sum_next = sum_reg + term_reg;
                    term_next = term_reg << v_reg;
                    k_next = k_reg + 1'b1;
                end
            end
            S_FIN: begin
                cnt_next = COUNT_WIDTH'(prod_reg * (sum_reg + 1'b1));
                state_next = S_DONE;
            end
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            req <= '0;
        end else begin
            state_reg <= state_next;
            req <= req_next;
        end
        nodd_reg <= nodd_next; rest_reg <= rest_next; d_reg <= d_next;
        p_reg <= p_next; ga_reg <= ga_next; gb_reg <= gb_next;
        prod_reg <= prod_next; sum_reg <= sum_next; term_reg <= term_next;
        r_reg <= r_next; rmin_reg <= rmin_next; v_reg <= v_next; k_reg <= k_next;
        bad_reg <= bad_next; cnt_reg <= cnt_next;
    end

    assign idle = (state_reg == S_IDLE);
    assign done = (state_reg == S_DONE);
    assign liar_count = cnt_reg;
    assign bad_input = bad_reg;
endmodule

/* sim/strong_liar_count_monier_tb.sv */
`timescale 1ns / 1ps
module strong_liar_count_monier_tb;
    import slcm_pkg::*;

    typedef struct {
        logic [31:0] count;
        logic        bad;
    } liar_result_t;

    // expected liar counts in arrival order
    class liar_scoreboard;
        liar_result_t pending[$];
        int unsigned  errors;

        static function longint unsigned odd_of(longint unsigned x);
            if (x == 0) return 0;
            while (!x[0]) x = x >> 1;
            return x;
        endfunction

        static function int unsigned twos_of(longint unsigned x);
            int unsigned k;
            k = 0;
            if (x == 0) return 0;
            while (!x[0]) begin
                x = x >> 1;
                k++;
            end
            return k;
        endfunction

        static function longint unsigned gcd_of(longint unsigned a, longint unsigned b);
            longint unsigned t;
            while (b != 0) begin
                t = a % b;
                a = b;
                b = t;
            end
            return a;
        endfunction

        // monier count for one number
        static function liar_result_t count_liars(logic [31:0] number);
            liar_result_t     res;
            longint unsigned  n, rest, d, p, nodd, prod, sum, term;
            int unsigned      v, rmin, r;
            n = number;
            prod = 1; sum = 0; term = 1; v = 0; rmin = 0;
            if (n < 3 || !n[0]) begin
                res.count = '0;
                res.bad   = 1'b1;
                return res;
            end
            nodd = odd_of(n - 1);
            rest = n;
            d = 3;
            while (rest > 1) begin
                if (d <= rest / d) begin
                    if (rest % d != 0) begin
                        d += 2;
                        continue;
                    end
                    p = d;
                    while (rest % p == 0) rest = rest / p;
                end else begin
                    p = rest;
                    rest = 1;
                end
                r = twos_of(p - 1);
                prod *= gcd_of(nodd, odd_of(p - 1));
                if (v == 0 || r < rmin) rmin = r;
                v++;
            end
            for (int unsigned k = 0; k < rmin; k++) begin
                sum += term;
                if (k + 1 < rmin && v < 64) term = term << v;
            end
            res.count = 32'(prod * (1 + sum));
            res.bad   = 1'b0;
            return res;
        endfunction

        function void note_number(logic [31:0] number);
            pending.insert(pending.size(), count_liars(number));
        endfunction

        function void check_result(logic [31:0] count, logic bad);
            liar_result_t exp_res;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word count=%0d bad=%0b", $time, count, bad);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (count !== exp_res.count) begin
                $display("%0t: liar_count expected %0d actual %0d",
                         $time, exp_res.count, count);
                errors++;
            end
            if (bad !== exp_res.bad) begin
                $display("%0t: bad_input expected %0b actual %0b",
                         $time, exp_res.bad, bad);
                errors++;
            end
        endfunction
    endclass

    localparam longint CYCLE_LIMIT = 64'd500_000_000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [TDATA_IN_W-1:0] s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [COUNT_WIDTH-1:0] m_tdata;
    logic                  m_tuser;

    liar_scoreboard board;
    longint         cycle_count = 0;

    strong_liar_count_monier dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
    end

    // send one number, with a random gap first
    task automatic send_number(logic [31:0] number);
        int unsigned gap;
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= number;
        do @(posedge aclk); while (!s_tready);
        board.note_number(number);
    endtask

    // random number, mostly odd and small so trial division stays quick
    function automatic logic [31:0] pick_number();
        logic [31:0] x;
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)      x = $urandom_range(3, 20000);
        else if (sel < 80) x = $urandom_range(3, 2000000);
        else if (sel < 88) x = $urandom;                        // any bits, may be even
        else if (sel < 94) x = 32'($urandom_range(3, 4000)) * $urandom_range(3, 4000);
        else               x = $urandom_range(0, 3);
        if (sel < 80 || (sel >= 88 && sel < 94)) x[0] = 1'b1;
        return x;
    endfunction

    // receiver with random stalls per word
    initial begin
        int unsigned stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            board.check_result(m_tdata, m_tuser);
        end
    end

    // timeout watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        logic [31:0] directed[$];
        board = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // below three, even numbers, smallest primes, prime powers,
        // carmichael numbers, strong pseudoprimes and wide values
        directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd15,
                     32'd25, 32'd27, 32'd561, 32'd1105, 32'd2047, 32'd3277,
                     32'd65537, 32'd1373653, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                     32'hAAAA_AAAB, 32'h5555_5555, 32'd4294967291,
                     32'h8000_0001};
        foreach (directed[i]) send_number(directed[i]);
        repeat (80) send_number(pick_number());
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (board.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
